>>> rtl/core/gtsc_pkg.sv
// Shared types, constants and the control program ROM for the gyro turn speed controller.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package gtsc_pkg;

    // Input item: button, yaw and left wheel velocity for one control tick.
    typedef struct packed {
        logic               turn_button;
        logic signed [15:0] yaw;
        logic signed [15:0] left_velocity;
    } in_item_t;

    // Result item: wheel drive commands and turn completion flags.
    typedef struct packed {
        logic               drive_valid;
        logic signed [15:0] left_drive;
        logic signed [15:0] right_drive;
        logic               turn_done;
        logic               reset_yaw;
    } out_item_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [12:0] target_angle;
        logic [14:0] min_speed;
        logic [14:0] top_speed;
        logic [11:0] stop_band;
        logic [23:0] softness;
        logic [14:0] slow_threshold;
        logic [7:0]  settle_ticks;
    } cfg_t;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_BAND      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOFTNESS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS   = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [12:0] RST_TARGET_ANGLE   = 13'd2880;
    localparam logic [14:0] RST_MIN_SPEED      = 15'd7537;
    localparam logic [14:0] RST_TOP_SPEED      = 15'd16384;
    localparam logic [11:0] RST_STOP_BAND      = 12'd56;
    localparam logic [23:0] RST_SOFTNESS       = 24'd332800;
    localparam logic [14:0] RST_SLOW_THRESHOLD = 15'd108;
    localparam logic [7:0]  RST_SETTLE_TICKS   = 8'd13;

    // Serial divider: one quotient bit per step, quotient never exceeds 15 bits.
    localparam int                DIV_STEPS = 15;
    localparam int                DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Datapath operations selected by the control word.
    typedef enum logic [2:0] {
        OP_FETCH = 3'd0,
        OP_ABS   = 3'd1,
        OP_SQR   = 3'd2,
        OP_MUL   = 3'd3,
        OP_NUM   = 3'd4,
        OP_DIV   = 3'd5,
        OP_OUT   = 3'd6
    } op_t;

    // Jump conditions: the jump is taken when the condition holds.
    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,
        COND_NO_INPUT = 2'd1,
        COND_DIV_MORE = 2'd2,
        COND_OUT_BUSY = 2'd3
    } cond_t;

    // Program counter and step addresses.
    localparam int PC_W = 3;

    localparam logic [PC_W-1:0] STEP_FETCH = 3'd0;
    localparam logic [PC_W-1:0] STEP_ABS   = 3'd1;
    localparam logic [PC_W-1:0] STEP_SQR   = 3'd2;
    localparam logic [PC_W-1:0] STEP_MUL   = 3'd3;
    localparam logic [PC_W-1:0] STEP_NUM   = 3'd4;
    localparam logic [PC_W-1:0] STEP_DIV   = 3'd5;
    localparam logic [PC_W-1:0] STEP_OUT   = 3'd6;
    localparam logic [PC_W-1:0] STEP_LAST  = STEP_OUT;

    // One control word per program step.
    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // Condition flags reported by the datapath.
    typedef struct packed {
        logic no_input;
        logic div_more;
        logic out_busy;
    } status_t;

    // Control program. Unused addresses hold a harmless scratch operation.
    function automatic ctrl_word_t prog_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t word;
        case (pc)
            STEP_FETCH: word = '{op: OP_FETCH, cond: COND_NO_INPUT, target: STEP_FETCH};
            STEP_ABS:   word = '{op: OP_ABS,   cond: COND_NONE,     target: STEP_FETCH};
            STEP_SQR:   word = '{op: OP_SQR,   cond: COND_NONE,     target: STEP_FETCH};
            STEP_MUL:   word = '{op: OP_MUL,   cond: COND_NONE,     target: STEP_FETCH};
            STEP_NUM:   word = '{op: OP_NUM,   cond: COND_NONE,     target: STEP_FETCH};
            STEP_DIV:   word = '{op: OP_DIV,   cond: COND_DIV_MORE, target: STEP_DIV};
            STEP_OUT:   word = '{op: OP_OUT,   cond: COND_OUT_BUSY, target: STEP_OUT};
            default:    word = '{op: OP_SQR,   cond: COND_NONE,     target: STEP_FETCH};
        endcase
        return word;
    endfunction

endpackage

>>> rtl/core/gtsc_sequencer.sv
// Microcode sequencer: program counter, control ROM lookup and conditional jumps.
// Depends on gtsc_pkg for the control word, status and program ROM.
`timescale 1ns / 1ps

module gtsc_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gtsc_pkg::status_t    status,
    output gtsc_pkg::ctrl_word_t ctrl,
    output logic                 in_ready
);
    import gtsc_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            jump;

    // Fetch the control word of the current step.
    assign ctrl     = prog_rom(pc_reg);
    assign in_ready = (pc_reg == STEP_FETCH);

    // Evaluate the jump condition of this step.
    always_comb
    begin
        case (ctrl.cond)
            COND_NONE:     jump = 1'b0;
            COND_NO_INPUT: jump = status.no_input;
            COND_DIV_MORE: jump = status.div_more;
            COND_OUT_BUSY: jump = status.out_busy;
            default:       jump = 1'b0;
        endcase
    end

    // Jump, or advance and wrap back to the fetch step after the last step.
    always_comb
    begin
        if (jump)
        begin
            pc_next = ctrl.target;
        end
        else if (pc_reg == STEP_LAST)
        begin
            pc_next = STEP_FETCH;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> rtl/core/gtsc_datapath.sv
// Datapath: input capture, squaring and multiply, serial divider, settle timer and output register.
// Depends on gtsc_pkg; driven by the control word from gtsc_sequencer.
`timescale 1ns / 1ps

module gtsc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gtsc_pkg::ctrl_word_t ctrl,
    input  gtsc_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    input  gtsc_pkg::in_item_t   in_item,
    input  logic                 out_ready,
    output logic                 out_valid,
    output gtsc_pkg::out_item_t  out_item,
    output gtsc_pkg::status_t    status
);
    import gtsc_pkg::*;

    // Captured item.
    logic               button_reg;
    logic signed [15:0] yaw_reg;
    logic signed [15:0] vel_reg;

    // Error and speed span.
    logic               e_neg_reg;
    logic [15:0]        ae_reg;
    logic               d_neg_reg;
    logic [14:0]        ad_reg;

    // Products and divider.
    logic [30:0]        e2_reg;
    logic [45:0]        prod_reg;
    logic [30:0]        den_reg;
    logic [30:0]        rem_reg;
    logic [14:0]        num_lo_reg;
    logic [14:0]        quot_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Settle timer.
    logic               armed_reg;
    logic               running_reg;
    logic [7:0]         count_reg;

    // Output register.
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic               out_busy;
    logic               out_load;

    assign out_busy = out_valid_reg && !out_ready;
    assign out_load = (ctrl.op == OP_OUT) && !out_busy;

    assign status.no_input = !in_valid;
    assign status.div_more = (div_cnt_reg != DIV_LAST);
    assign status.out_busy = out_busy;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Error magnitude and sign, speed span magnitude and sign.
    logic [15:0] ayaw;
    logic [16:0] e_full;
    logic [16:0] e_mag;
    logic [15:0] d_full;
    logic [15:0] d_mag;

    always_comb
    begin
        ayaw   = yaw_reg[15] ? (~yaw_reg + 16'sd1) : yaw_reg;
        e_full = {1'b0, ayaw} - {4'b0, cfg.target_angle};
        e_mag  = e_full[16] ? (~e_full + 17'd1) : e_full;
        d_full = {1'b0, cfg.top_speed} - {1'b0, cfg.min_speed};
        d_mag  = d_full[15] ? (~d_full + 16'd1) : d_full;
    end

    // Multipliers and the rounding adder, each feeding a register.
    logic [31:0] e2_full;
    logic [45:0] prod_full;
    logic [45:0] num_full;

    assign e2_full   = 32'(ae_reg) * 32'(ae_reg);
    assign prod_full = 46'(ad_reg) * 46'(e2_reg);
    assign num_full  = prod_reg + 46'(den_reg >> 1);

    // One restoring division step.
    logic [31:0] trial;
    logic        trial_ge;
    logic [31:0] trial_sub;

    assign trial     = {rem_reg, num_lo_reg[14]};
    assign trial_ge  = (trial >= {1'b0, den_reg});
    assign trial_sub = trial - {1'b0, den_reg};

    // Speed curve, stop band and settle timer for the result item.
    logic [14:0] term;
    logic [15:0] m_val;
    logic [15:0] speed;
    logic [15:0] vel_mag;
    logic        slow;
    logic        armed_a;
    logic        running_a;
    logic [7:0]  count_a;
    logic        done;
    logic        armed_f;
    logic        running_f;
    logic [7:0]  count_f;
    logic [15:0] drive;

    always_comb
    begin
        term    = (den_reg == '0) ? 15'd0 : quot_reg;
        m_val   = d_neg_reg ? ({1'b0, cfg.min_speed} - {1'b0, term})
                            : ({1'b0, cfg.min_speed} + {1'b0, term});
        speed   = e_neg_reg ? (~m_val + 16'd1) : m_val;
        vel_mag = vel_reg[15] ? (~vel_reg + 16'sd1) : vel_reg;
        slow    = (vel_mag <= {1'b0, cfg.slow_threshold});

        armed_a   = armed_reg;
        running_a = running_reg;
        count_a   = count_reg;
        done      = 1'b0;
        drive     = 16'd0;

        // Velocity check arms, starts or clears the timer while the button is held.
        if (button_reg)
        begin
            if (slow)
            begin
                if (armed_reg)
                begin
                    running_a = 1'b1;
                    armed_a   = 1'b0;
                end
            end
            else
            begin
                armed_a   = 1'b1;
                running_a = 1'b0;
                count_a   = 8'd0;
            end

            if (count_a >= cfg.settle_ticks)
            begin
                done      = 1'b1;
                running_a = 1'b0;
                count_a   = 8'd0;
            end
            else if (ae_reg > {4'b0, cfg.stop_band})
            begin
                drive = speed;
            end
        end

        // A running timer counts once per tick and saturates.
        armed_f   = armed_a;
        running_f = running_a;
        count_f   = (running_a && (count_a != 8'hFF)) ? (count_a + 8'd1) : count_a;
    end

    // Datapath registers, loaded by the operation of the current step.
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_FETCH:
            begin
                if (in_valid)
                begin
                    button_reg <= in_item.turn_button;
                    yaw_reg    <= in_item.yaw;
                    vel_reg    <= in_item.left_velocity;
                end
            end
            OP_ABS:
            begin
                e_neg_reg <= e_full[16];
                ae_reg    <= e_mag[15:0];
                d_neg_reg <= d_full[15];
                ad_reg    <= d_mag[14:0];
            end
            OP_SQR:
            begin
                e2_reg <= e2_full[30:0];
            end
            OP_MUL:
            begin
                prod_reg <= prod_full;
                den_reg  <= e2_reg + {7'b0, cfg.softness};
            end
            OP_NUM:
            begin
                rem_reg    <= num_full[45:15];
                num_lo_reg <= num_full[14:0];
                quot_reg   <= 15'd0;
            end
            OP_DIV:
            begin
                rem_reg    <= trial_ge ? trial_sub[30:0] : trial[30:0];
                num_lo_reg <= {num_lo_reg[13:0], 1'b0};
                quot_reg   <= {quot_reg[13:0], trial_ge};
            end
            OP_OUT:
            begin
                if (out_load)
                begin
                    out_item_reg.drive_valid <= button_reg;
                    out_item_reg.left_drive  <= drive;
                    out_item_reg.right_drive <= ~drive + 16'd1;
                    out_item_reg.turn_done   <= done;
                    out_item_reg.reset_yaw   <= done;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state: divider step count, settle timer and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg   <= '0;
            armed_reg     <= 1'b1;
            running_reg   <= 1'b0;
            count_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.op == OP_NUM)
            begin
                div_cnt_reg <= '0;
            end
            else if (ctrl.op == OP_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end

            if (out_load)
            begin
                armed_reg     <= armed_f;
                running_reg   <= running_f;
                count_reg     <= count_f;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // The timer never runs while it is armed.
    a_armed_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        !(armed_reg && running_reg))
        else $error("settle timer armed and running at once");

    // A completed turn always leaves the timer stopped and cleared.
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && done) |=> (!running_reg && (count_reg == 8'd0)))
        else $error("settle timer not cleared after turn completion");

    // The divider only runs its fixed number of steps.
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_DIV) |-> (div_cnt_reg <= DIV_LAST))
        else $error("divider ran past its last step");
`endif

endmodule

>>> rtl/core/gyro_turn_speed_controller.sv
// Each accepted input item runs through the fetch, error, square, multiply, numerator,
// 15-step serial divider and result steps in order before the next item is taken,
// and the result step waits while the previous result is still held in the output register.
// Reset: rst_n is asynchronous and active low; it restores the register defaults,
// arms the settle timer and empties the output register. No clearing pass is needed.
// Top level of the gyro turn speed controller: configuration registers and module wiring.
// Depends on gtsc_pkg, gtsc_sequencer and gtsc_datapath.
`timescale 1ns / 1ps

module gyro_turn_speed_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [gtsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gtsc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  gtsc_pkg::in_item_t                 in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output gtsc_pkg::out_item_t                out_item
);
    import gtsc_pkg::*;

    cfg_t       cfg_reg;
    ctrl_word_t ctrl;
    status_t    status;

    // Configuration registers, written by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_angle   <= RST_TARGET_ANGLE;
            cfg_reg.min_speed      <= RST_MIN_SPEED;
            cfg_reg.top_speed      <= RST_TOP_SPEED;
            cfg_reg.stop_band      <= RST_STOP_BAND;
            cfg_reg.softness       <= RST_SOFTNESS;
            cfg_reg.slow_threshold <= RST_SLOW_THRESHOLD;
            cfg_reg.settle_ticks   <= RST_SETTLE_TICKS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TARGET_ANGLE:   cfg_reg.target_angle   <= cfg_data[12:0];
                REG_MIN_SPEED:      cfg_reg.min_speed      <= cfg_data[14:0];
                REG_TOP_SPEED:      cfg_reg.top_speed      <= cfg_data[14:0];
                REG_STOP_BAND:      cfg_reg.stop_band      <= cfg_data[11:0];
                REG_SOFTNESS:       cfg_reg.softness       <= cfg_data[23:0];
                REG_SLOW_THRESHOLD: cfg_reg.slow_threshold <= cfg_data[14:0];
                REG_SETTLE_TICKS:   cfg_reg.settle_ticks   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control program sequencer.
    gtsc_sequencer u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    // Arithmetic, settle timer and output register.
    gtsc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .status    (status)
    );

`ifndef NO_ASSERTIONS
    // After an item is taken, no other item is taken until it is worked off.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while one is in flight");

    // The right drive always mirrors the left drive.
    a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.right_drive == -out_item.left_drive))
        else $error("right drive is not the negation of left drive");

    // A finished turn gives zero drive and a yaw reset pulse, and only while held.
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.turn_done) |->
        ((out_item.left_drive == 16'sd0) && out_item.reset_yaw && out_item.drive_valid))
        else $error("turn completion with nonzero drive or missing yaw reset");
`endif

endmodule

>>> tb/gtsc_checker.sv
// Checker for the gyro turn speed controller: predicts each drive command and compares it.
// Depends on gtsc_pkg; watches the configuration port and both item channels of the block.
`timescale 1ns / 1ps

module gtsc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [gtsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gtsc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  gtsc_pkg::in_item_t              in_item,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  gtsc_pkg::out_item_t             out_item,
    output int                              mismatches,
    output int                              outstanding,
    output int                              checked,
    output int                              turns_done
);

    import gtsc_pkg::*;

    // Shadow copy of the configuration registers.
    int cfg_target;
    int cfg_min;
    int cfg_max;
    int cfg_stop;
    int cfg_soft;
    int cfg_slow;
    int cfg_settle;

    // Shadow copy of the settle timer.
    bit settle_armed;
    bit settle_running;
    int settle_count;

    // Drive commands predicted for accepted items, oldest first.
    out_item_t expected_cmds[$];

    int miss_total;
    int checked_total;
    int done_total;

    assign mismatches = miss_total;
    assign checked    = checked_total;
    assign turns_done = done_total;

    // Prints one line per mismatch; past the first 40 only the count grows.
    task automatic report(input string msg);
        if (miss_total < 40)
        begin
            $display("MISMATCH: %s", msg);
        end
        miss_total++;
    endtask

    // Works out the drive command for one control tick and advances the settle timer.
    function automatic out_item_t turn_command(input in_item_t it);
        longint yaw_mag;
        longint err;
        longint err_mag;
        longint err_sq;
        longint den;
        longint diff;
        longint diff_mag;
        longint term;
        longint mag;
        longint speed;
        longint vel_mag;
        longint drive;
        bit finished;
        out_item_t cmd;

        drive    = 0;
        finished = 1'b0;
        if (it.turn_button)
        begin
            yaw_mag  = (it.yaw < 0) ? -longint'(it.yaw) : longint'(it.yaw);
            err      = yaw_mag - cfg_target;
            err_mag  = (err < 0) ? -err : err;
            err_sq   = err_mag * err_mag;
            den      = err_sq + cfg_soft;
            diff     = cfg_max - cfg_min;
            diff_mag = (diff < 0) ? -diff : diff;
            // Rounded curve term; a zero divisor only arises at zero error, where it is zero.
            term     = (den != 0) ? (diff_mag * err_sq + den / 2) / den : 0;
            mag      = cfg_min + ((diff < 0) ? -term : term);
            speed    = (err >= 0) ? mag : -mag;

            // Slow wheels start an armed timer; fast wheels re-arm and clear it.
            vel_mag = (it.left_velocity < 0) ? -longint'(it.left_velocity)
                                             : longint'(it.left_velocity);
            if (vel_mag <= cfg_slow)
            begin
                if (settle_armed)
                begin
                    settle_running = 1'b1;
                    settle_armed   = 1'b0;
                end
            end
            else
            begin
                settle_armed   = 1'b1;
                settle_running = 1'b0;
                settle_count   = 0;
            end

            if (settle_count >= cfg_settle)
            begin
                finished       = 1'b1;
                settle_running = 1'b0;
                settle_count   = 0;
            end
            else
            begin
                drive = (err_mag <= cfg_stop) ? 0 : speed;
            end
        end

        // A running timer counts every tick, held or not, and saturates.
        if (settle_running && settle_count < 255)
        begin
            settle_count++;
        end

        cmd.drive_valid = it.turn_button;
        cmd.left_drive  = 16'(drive);
        cmd.right_drive = 16'(-drive);
        cmd.turn_done   = finished;
        cmd.reset_yaw   = finished;
        return cmd;
    endfunction

    // Compares one returned item with the oldest prediction, field by field.
    task automatic check_result(input out_item_t got);
        out_item_t want;

        if (expected_cmds.size() == 0)
        begin
            report($sformatf("result %0d arrived with no item outstanding", checked_total));
        end
        else
        begin
            want = expected_cmds.pop_front();
            if (want.turn_done)
            begin
                done_total++;
            end
            if (got.drive_valid !== want.drive_valid)
            begin
                report($sformatf("result %0d drive_valid is %0d, expected %0d",
                                 checked_total, got.drive_valid, want.drive_valid));
            end
            if (got.left_drive !== want.left_drive)
            begin
                report($sformatf("result %0d left_drive is %0d, expected %0d",
                                 checked_total, got.left_drive, want.left_drive));
            end
            if (got.right_drive !== want.right_drive)
            begin
                report($sformatf("result %0d right_drive is %0d, expected %0d",
                                 checked_total, got.right_drive, want.right_drive));
            end
            if (got.turn_done !== want.turn_done)
            begin
                report($sformatf("result %0d turn_done is %0d, expected %0d",
                                 checked_total, got.turn_done, want.turn_done));
            end
            if (got.reset_yaw !== want.reset_yaw)
            begin
                report($sformatf("result %0d reset_yaw is %0d, expected %0d",
                                 checked_total, got.reset_yaw, want.reset_yaw));
            end
        end
        checked_total++;
    endtask

    initial
    begin
        miss_total    = 0;
        checked_total = 0;
        done_total    = 0;
    end

    // Follow resets, register writes and both channels at every clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_target     = int'(RST_TARGET_ANGLE);
            cfg_min        = int'(RST_MIN_SPEED);
            cfg_max        = int'(RST_TOP_SPEED);
            cfg_stop       = int'(RST_STOP_BAND);
            cfg_soft       = int'(RST_SOFTNESS);
            cfg_slow       = int'(RST_SLOW_THRESHOLD);
            cfg_settle     = int'(RST_SETTLE_TICKS);
            settle_armed   = 1'b1;
            settle_running = 1'b0;
            settle_count   = 0;
            expected_cmds.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_result(out_item);
            end
            if (in_valid && in_ready)
            begin
                expected_cmds.push_back(turn_command(in_item));
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TARGET_ANGLE:   cfg_target = int'(cfg_data[12:0]);
                    REG_MIN_SPEED:      cfg_min    = int'(cfg_data[14:0]);
                    REG_TOP_SPEED:      cfg_max    = int'(cfg_data[14:0]);
                    REG_STOP_BAND:      cfg_stop   = int'(cfg_data[11:0]);
                    REG_SOFTNESS:       cfg_soft   = int'(cfg_data[23:0]);
                    REG_SLOW_THRESHOLD: cfg_slow   = int'(cfg_data[14:0]);
                    REG_SETTLE_TICKS:   cfg_settle = int'(cfg_data[7:0]);
                    default:            ;
                endcase
            end
            outstanding <= expected_cmds.size();
        end
    end

endmodule

>>> tb/tb_gyro_turn_speed_controller.sv
// Testbench top for the gyro turn speed controller: clock, reset, stimulus and verdict.
// Depends on gtsc_pkg, the block itself and gtsc_checker, which does all the comparing.
`timescale 1ns / 1ps

module tb_gyro_turn_speed_controller;

    import gtsc_pkg::*;

    localparam int CYCLE_LIMIT = 900000;
    localparam int DRAIN_WAIT  = 25;
    localparam int HOLD_CYCLES = 400;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;

    int mismatches;
    int outstanding;
    int checked;
    int turns_done;

    int items_sent    = 0;
    int settings_used = 1;
    int cycle_count   = 0;
    bit steady        = 1'b0;
    bit hold_request  = 1'b0;
    bit hold_taken    = 1'b0;

    cfg_t cur_cfg = '{RST_TARGET_ANGLE, RST_MIN_SPEED, RST_TOP_SPEED, RST_STOP_BAND,
                      RST_SOFTNESS, RST_SLOW_THRESHOLD, RST_SETTLE_TICKS};

    gyro_turn_speed_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    gtsc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .turns_done  (turns_done)
    );

    always #6 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: random stalls, none while steady, and one long hold when asked.
    always
    begin
        @(posedge clk);
        if (hold_request && !hold_taken)
        begin
            hold_taken = 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
        end
        out_ready <= steady || ($urandom_range(0, 99) >= 34);
    end

    // Builds one item, clamping yaw and velocity to the 16-bit range.
    function automatic in_item_t pack(input bit held, input int yaw_val, input int vel_val);
        in_item_t it;

        if (yaw_val > 32767) yaw_val = 32767;
        if (yaw_val < -32768) yaw_val = -32768;
        if (vel_val > 32767) vel_val = 32767;
        if (vel_val < -32768) vel_val = -32768;
        it.turn_button   = held;
        it.yaw           = 16'(yaw_val);
        it.left_velocity = 16'(vel_val);
        return it;
    endfunction

    // Velocity strictly above the slow threshold; -32768 is always fast enough.
    function automatic int fast_vel();
        int mag;

        mag = $urandom_range(int'(cur_cfg.slow_threshold) + 1, 32768);
        if (mag == 32768)
        begin
            return -32768;
        end
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic int slow_vel();
        int mag;

        mag = $urandom_range(0, int'(cur_cfg.slow_threshold));
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Yaw near the target on the given side, around the stop band, sometimes exactly on it.
    function automatic int near_yaw(input int dir);
        int band;
        int off;

        band = int'(cur_cfg.stop_band) + 16;
        off  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 2 * band) - band;
        return dir * (int'(cur_cfg.target_angle) + off);
    endfunction

    function automatic in_item_t noise_item();
        return pack($urandom_range(0, 1), $urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 65535) - 32768);
    endfunction

    // Offers one item, sometimes after a random gap unless steady, and waits for it to be taken.
    task automatic offer(input in_item_t it);
        if (!steady && $urandom_range(0, 99) < 34)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Stops offering and waits until every predicted command has come back.
    task automatic finish_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    // Writes every register; only called while the block is idle.
    task automatic load_config(input cfg_t c);
        put_reg(REG_TARGET_ANGLE, int'(c.target_angle));
        put_reg(REG_MIN_SPEED, int'(c.min_speed));
        put_reg(REG_TOP_SPEED, int'(c.top_speed));
        put_reg(REG_STOP_BAND, int'(c.stop_band));
        put_reg(REG_SOFTNESS, int'(c.softness));
        put_reg(REG_SLOW_THRESHOLD, int'(c.slow_threshold));
        put_reg(REG_SETTLE_TICKS, int'(c.settle_ticks));
        cfg_write <= 1'b0;
        @(posedge clk);
        cur_cfg = c;
        settings_used++;
    endtask

    function automatic cfg_t random_cfg();
        cfg_t c;

        c.target_angle   = 13'($urandom_range(0, 5760));
        c.min_speed      = 15'($urandom_range(0, 32767));
        c.top_speed      = 15'($urandom_range(0, 32767));
        c.stop_band      = 12'($urandom_range(0, 300));
        c.softness       = 24'($urandom_range(1, 255) << $urandom_range(0, 16));
        c.slow_threshold = 15'($urandom_range(0, 2000));
        c.settle_ticks   = 8'($urandom_range(1, 20));
        return c;
    endfunction

    // One turn: fast approach, slow settle near the target with rare blips, then up to two noise items.
    task automatic play_turn();
        int dir;
        int fast_n;
        int slow_n;
        int pick;

        dir    = $urandom_range(0, 1) ? 1 : -1;
        fast_n = $urandom_range(1, 6);
        for (int k = 1; k <= fast_n; k++)
        begin
            offer(pack(1'b1, dir * int'(cur_cfg.target_angle) * k / fast_n
                             + int'($urandom_range(0, 200)) - 100, fast_vel()));
        end
        slow_n = int'(cur_cfg.settle_ticks) + $urandom_range(1, 3);
        for (int k = 0; k < slow_n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                offer(pack(1'b0, near_yaw(dir), slow_vel()));
            end
            else if (pick < 7)
            begin
                offer(pack(1'b1, near_yaw(dir), fast_vel()));
            end
            else
            begin
                offer(pack(1'b1, near_yaw(dir), slow_vel()));
            end
        end
        repeat ($urandom_range(0, 2)) offer(noise_item());
    endtask

    // Mostly whole turns with some noise, until the phase has used its share of items.
    task automatic run_phase(input int quota);
        int first;

        first = items_sent;
        while (items_sent - first < quota)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                play_turn();
            end
            else
            begin
                repeat ($urandom_range(1, 5)) offer(noise_item());
            end
        end
        finish_phase();
    endtask

    // Timer started, then a long release so the count saturates before a held finish.
    task automatic coast_to_saturation();
        offer(pack(1'b1, 0, fast_vel()));
        offer(pack(1'b1, 0, slow_vel()));
        repeat (260) offer(pack(1'b0, $urandom_range(0, 65535) - 32768, fast_vel()));
        offer(pack(1'b1, int'(cur_cfg.target_angle), slow_vel()));
    endtask

    initial
    begin
        cfg_t edge_low;
        cfg_t edge_high;
        cfg_t flat_curve;

        edge_low   = '{13'd0, 15'd0, 15'd32767, 12'd0, 24'd1, 15'd0, 8'd1};
        edge_high  = '{13'd8191, 15'd32767, 15'd0, 12'd4095, 24'hFFFFFF, 15'd32767, 8'd255};
        flat_curve = '{13'($urandom_range(1, 5760)), 15'd1000, 15'd30000, 12'd0, 24'd0,
                       15'd500, 8'd0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset settings: field extremes, released ticks,
        // zero error, the stop band edges, and one complete settle.
        offer(pack(1'b0, 0, 0));
        offer(pack(1'b0, -32768, 32767));
        offer(pack(1'b1, 32767, -32768));
        offer(pack(1'b1, -32768, 32767));
        offer(pack(1'b1, 2880, 5000));
        offer(pack(1'b1, -2880, -5000));
        offer(pack(1'b1, 2936, 300));
        offer(pack(1'b1, -2937, 300));
        offer(pack(1'b1, 2824, -300));
        offer(pack(1'b1, 2823, 109));
        offer(pack(1'b1, 0, 108));
        // The timer keeps counting while the button is released.
        repeat (3) offer(pack(1'b0, 1000, -20000));
        for (int k = 0; k < 10; k++)
        begin
            offer(pack(1'b1, 2880 + k * 20, (k % 2 == 1) ? -108 : 108));
        end
        // Disarmed after the finish: a slow tick must not restart the timer.
        offer(pack(1'b1, 2880, 0));
        finish_phase();

        run_phase(250);

        load_config(edge_low);
        run_phase(250);

        load_config(edge_high);
        coast_to_saturation();
        run_phase(30);

        // Zero softness with zero error, and zero settle length finishing every held tick.
        load_config(flat_curve);
        offer(pack(1'b1, int'(flat_curve.target_angle), 0));
        offer(pack(1'b1, -int'(flat_curve.target_angle), 5000));
        offer(pack(1'b0, int'(flat_curve.target_angle), 0));
        offer(pack(1'b1, -int'(flat_curve.target_angle), -500));
        run_phase(240);

        // A stretch with no idling on either side.
        steady = 1'b1;
        load_config(random_cfg());
        run_phase(250);
        steady = 1'b0;

        // The receiver holds off while items keep coming, so the block backs up.
        load_config(random_cfg());
        hold_request = 1'b1;
        run_phase(250);

        load_config(random_cfg());
        run_phase(100);
        load_config(random_cfg());
        run_phase(70);

        $display("Covered %0d items under %0d register settings, %0d checked, %0d turns done.",
                 items_sent, settings_used, checked, turns_done);
        $display("Also a settle timer saturating over a long release and a long output stall.");
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/gtsc_pkg.sv
rtl/core/gtsc_sequencer.sv
rtl/core/gtsc_datapath.sv
rtl/core/gyro_turn_speed_controller.sv
tb/gtsc_checker.sv
tb/tb_gyro_turn_speed_controller.sv
